@@ sv/dpsm_pkg.sv @@
// Package for the dual-axis PD steering mixer.
// Holds field widths, APB port widths, register map codes, reset values and the mode code type.
// No dependencies.
package dpsm_pkg;

    // Field widths
    localparam int OFFSET_W = 11;
    localparam int DUTY_W   = 12;
    localparam int GAIN_W   = 8;
    localparam int LIMIT_W  = 7;
    localparam int DBAND_W  = 10;
    localparam int MODE_W   = 2;

    // APB port geometry
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register map: index = paddr[4:2]
    typedef enum logic [2:0] {
        REG_STEER_GAIN_P = 3'd0,
        REG_STEER_GAIN_D = 3'd1,
        REG_DRIVE_GAIN_P = 3'd2,
        REG_DRIVE_GAIN_D = 3'd3,
        REG_BASE_DUTY    = 3'd4,
        REG_TERM_LIMIT   = 3'd5,
        REG_DEAD_BAND    = 3'd6
    } t_reg_idx;

    // Register reset values
    localparam logic [GAIN_W-1:0]  RST_STEER_GAIN_P = 8'd5;
    localparam logic [GAIN_W-1:0]  RST_STEER_GAIN_D = 8'd2;
    localparam logic [GAIN_W-1:0]  RST_DRIVE_GAIN_P = 8'd5;
    localparam logic [GAIN_W-1:0]  RST_DRIVE_GAIN_D = 8'd2;
    localparam logic [DUTY_W-1:0]  RST_BASE_DUTY    = 12'd600;
    localparam logic [LIMIT_W-1:0] RST_TERM_LIMIT   = 7'd90;
    localparam logic [DBAND_W-1:0] RST_DEAD_BAND    = 10'd10;

    // Wheel mode codes
    typedef enum logic [MODE_W-1:0] {
        MODE_STOP      = 2'd0,
        MODE_STRAIGHT  = 2'd1,
        MODE_TURN_DRV  = 2'd2,
        MODE_TURN_ONLY = 2'd3
    } t_drive_mode;

endpackage

@@ sv/dpsm_if.sv @@
// Handshake interfaces for the measurement and wheel-duty channels.
// Depends on dpsm_pkg for field widths.
interface dpsm_meas_if;
    import dpsm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [OFFSET_W-1:0] horiz_offset;
    logic signed [OFFSET_W-1:0] vert_offset;
    logic                       target_found;

    modport source (output valid, horiz_offset, vert_offset, target_found, input ready);
    modport sink   (input valid, horiz_offset, vert_offset, target_found, output ready);
endinterface

interface dpsm_duty_if;
    import dpsm_pkg::*;
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] left_duty;
    logic [DUTY_W-1:0] right_duty;
    logic [MODE_W-1:0] drive_mode;

    modport source (output valid, left_duty, right_duty, drive_mode, input ready);
    modport sink   (input valid, left_duty, right_duty, drive_mode, output ready);
endinterface

@@ sv/dual_axis_pd_steering_mixer_core.sv @@
// Dual-axis PD steering mixer: camera offsets in, wheel duties and mode out.
// Depends on dpsm_pkg and the interfaces in dpsm_if.sv.
//
//   channel   | direction | handshake     | word
//   i_meas    | in        | valid/ready   | horiz_offset, vert_offset, target_found
//   o_duty    | out       | valid/ready   | left_duty, right_duty, drive_mode
//   APB       | in        | psel/penable  | seven control registers, pready tied high
//
// Three register stages: input capture, PD terms, wheel duties. An accepted word passes
// through all three to o_duty.valid, and one word can enter every cycle unless o_duty stalls.
// Each stage advances when it is empty or the next stage takes its word, so a stall
// on o_duty backs up through the stages and drops i_meas.ready when all are full.
// Synchronous active-low reset empties the pipe, zeroes the previous offsets and
// loads the register defaults.
module dual_axis_pd_steering_mixer_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    dpsm_meas_if.sink                i_meas,
    dpsm_duty_if.source              o_duty,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [dpsm_pkg::PADDR_W-1:0] paddr,
    input  logic [dpsm_pkg::PDATA_W-1:0] pwdata,
    output logic [dpsm_pkg::PDATA_W-1:0] prdata,
    output logic                     pready
);
    import dpsm_pkg::*;

    // Configuration registers
    logic [GAIN_W-1:0]  r_steer_gain_p, r_steer_gain_d;
    logic [GAIN_W-1:0]  r_drive_gain_p, r_drive_gain_d;
    logic [DUTY_W-1:0]  r_base_duty;
    logic [LIMIT_W-1:0] r_term_limit;
    logic [DBAND_W-1:0] r_dead_band;

    logic     cfg_wr;
    t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);

    // Write the selected register, keep only its own bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steer_gain_p <= RST_STEER_GAIN_P;
            r_steer_gain_d <= RST_STEER_GAIN_D;
            r_drive_gain_p <= RST_DRIVE_GAIN_P;
            r_drive_gain_d <= RST_DRIVE_GAIN_D;
            r_base_duty    <= RST_BASE_DUTY;
            r_term_limit   <= RST_TERM_LIMIT;
            r_dead_band    <= RST_DEAD_BAND;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_STEER_GAIN_P: r_steer_gain_p <= pwdata[GAIN_W-1:0];
                REG_STEER_GAIN_D: r_steer_gain_d <= pwdata[GAIN_W-1:0];
                REG_DRIVE_GAIN_P: r_drive_gain_p <= pwdata[GAIN_W-1:0];
                REG_DRIVE_GAIN_D: r_drive_gain_d <= pwdata[GAIN_W-1:0];
                REG_BASE_DUTY:    r_base_duty    <= pwdata[DUTY_W-1:0];
                REG_TERM_LIMIT:   r_term_limit   <= pwdata[LIMIT_W-1:0];
                REG_DEAD_BAND:    r_dead_band    <= pwdata[DBAND_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the selected register
    always_comb begin
        prdata = '0;
        case (cfg_idx)
            REG_STEER_GAIN_P: prdata = {{(PDATA_W-GAIN_W){1'b0}}, r_steer_gain_p};
            REG_STEER_GAIN_D: prdata = {{(PDATA_W-GAIN_W){1'b0}}, r_steer_gain_d};
            REG_DRIVE_GAIN_P: prdata = {{(PDATA_W-GAIN_W){1'b0}}, r_drive_gain_p};
            REG_DRIVE_GAIN_D: prdata = {{(PDATA_W-GAIN_W){1'b0}}, r_drive_gain_d};
            REG_BASE_DUTY:    prdata = {{(PDATA_W-DUTY_W){1'b0}}, r_base_duty};
            REG_TERM_LIMIT:   prdata = {{(PDATA_W-LIMIT_W){1'b0}}, r_term_limit};
            REG_DEAD_BAND:    prdata = {{(PDATA_W-DBAND_W){1'b0}}, r_dead_band};
            default:          prdata = '0;
        endcase
    end

    // PD term: kp*err + kd*(prev - err), exact in 22 bits
    function automatic logic signed [21:0] f_pd(
        input logic signed [OFFSET_W-1:0] err,
        input logic signed [OFFSET_W-1:0] prev,
        input logic [GAIN_W-1:0]          kp,
        input logic [GAIN_W-1:0]          kd
    );
        logic signed [11:0] diff;
        logic signed [19:0] p_part;
        logic signed [20:0] d_part;
        diff   = {prev[OFFSET_W-1], prev} - {err[OFFSET_W-1], err};
        p_part = $signed({1'b0, kp}) * err;
        d_part = $signed({1'b0, kd}) * diff;
        return 22'(p_part) + 22'(d_part);
    endfunction

    // True when |err| is below the deadband
    function automatic logic f_in_band(
        input logic signed [OFFSET_W-1:0] err,
        input logic [DBAND_W-1:0]         band
    );
        logic signed [11:0] wide;
        logic [11:0]        mag;
        wide = {err[OFFSET_W-1], err};
        mag  = err[OFFSET_W-1] ? 12'(-wide) : 12'(wide);
        return mag < {2'b00, band};
    endfunction

    // Saturate a signed duty sum to 0..4095
    function automatic logic [DUTY_W-1:0] f_sat(input logic signed [13:0] v);
        if (v[13]) begin
            return '0;
        end else if (v[12]) begin
            return '1;
        end else begin
            return v[DUTY_W-1:0];
        end
    endfunction

    // Pipeline handshake
    logic r_s1_valid, r_s2_valid, r_out_valid;
    logic s1_adv, s2_adv, out_adv, in_acc;

    assign out_adv      = !r_out_valid || o_duty.ready;
    assign s2_adv       = !r_s2_valid  || out_adv;
    assign s1_adv       = !r_s1_valid  || s2_adv;
    assign i_meas.ready = s1_adv;
    assign in_acc       = i_meas.valid && s1_adv;

    // Stage 1: capture the word and the previous offsets; advance the history
    logic signed [OFFSET_W-1:0] r_prev_horiz, r_prev_vert;
    logic signed [OFFSET_W-1:0] r_s1_ex, r_s1_ey, r_s1_px, r_s1_py;
    logic                       r_s1_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_prev_horiz <= '0;
            r_prev_vert  <= '0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= i_meas.valid;
            end
            if (in_acc) begin
                r_prev_horiz <= i_meas.horiz_offset;
                r_prev_vert  <= i_meas.vert_offset;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_ex    <= i_meas.horiz_offset;
            r_s1_ey    <= i_meas.vert_offset;
            r_s1_px    <= r_prev_horiz;
            r_s1_py    <= r_prev_vert;
            r_s1_found <= i_meas.target_found;
        end
    end

    // Stage 2: PD terms, clamp, deadband and target-lost zeroing
    logic signed [21:0]  pd_s, pd_d, lim_pos, lim_neg;
    logic signed [7:0]   n_steer;
    logic [LIMIT_W-1:0]  n_drive;
    logic signed [7:0]   r_s2_steer;
    logic [LIMIT_W-1:0]  r_s2_drive;

    always_comb begin
        pd_s    = f_pd(r_s1_ex, r_s1_px, r_steer_gain_p, r_steer_gain_d);
        pd_d    = f_pd(r_s1_ey, r_s1_py, r_drive_gain_p, r_drive_gain_d);
        lim_pos = $signed({{(22-LIMIT_W){1'b0}}, r_term_limit});
        lim_neg = -lim_pos;

        if (pd_s > lim_pos) begin
            n_steer = lim_pos[7:0];
        end else if (pd_s < lim_neg) begin
            n_steer = lim_neg[7:0];
        end else begin
            n_steer = pd_s[7:0];
        end
        if (f_in_band(r_s1_ex, r_dead_band) || !r_s1_found) begin
            n_steer = '0;
        end

        if (pd_d > lim_pos) begin
            n_drive = r_term_limit;
        end else if (pd_d[21]) begin
            n_drive = '0;
        end else begin
            n_drive = pd_d[LIMIT_W-1:0];
        end
        if (f_in_band(r_s1_ey, r_dead_band) || !r_s1_found) begin
            n_drive = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv && r_s1_valid) begin
            r_s2_steer <= n_steer;
            r_s2_drive <= n_drive;
        end
    end

    // Stage 3: mix terms into wheel duties and mode
    logic signed [13:0]  base_w, steer_w, drive_w;
    logic [DUTY_W-1:0]   n_left, n_right;
    t_drive_mode         n_mode;
    logic [DUTY_W-1:0]   r_left, r_right;
    t_drive_mode         r_mode;

    always_comb begin
        base_w  = $signed({2'b00, r_base_duty});
        steer_w = $signed({{6{r_s2_steer[7]}}, r_s2_steer});
        drive_w = $signed({{(14-LIMIT_W){1'b0}}, r_s2_drive});
        if (r_s2_steer == '0) begin
            if (r_s2_drive == '0) begin
                n_mode  = MODE_STOP;
                n_left  = '0;
                n_right = '0;
            end else begin
                n_mode  = MODE_STRAIGHT;
                n_left  = f_sat(base_w + drive_w);
                n_right = f_sat(base_w + drive_w);
            end
        end else begin
            n_mode  = (r_s2_drive != '0) ? MODE_TURN_DRV : MODE_TURN_ONLY;
            n_left  = f_sat(base_w + steer_w);
            n_right = f_sat(base_w - steer_w);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_s2_valid) begin
            r_left  <= n_left;
            r_right <= n_right;
            r_mode  <= n_mode;
        end
    end

    assign o_duty.valid      = r_out_valid;
    assign o_duty.left_duty  = r_left;
    assign o_duty.right_duty = r_right;
    assign o_duty.drive_mode = r_mode;

endmodule
